@@ rtl/dqfa_pkg.sv @@
// Shared types, constants and the answer record table for the DNS fixed-answer responder.
package dqfa_pkg;

    localparam int MAX_PACKET   = 512;
    localparam int POS_W        = $clog2(MAX_PACKET + 1);
    localparam int ANSWER_LEN   = 16;
    localparam int ANS_IDX_W    = $clog2(ANSWER_LEN);
    localparam int TAIL_LEN     = 4;
    localparam int TAIL_W       = 3;
    localparam int HEADER_LAST  = 11;
    localparam int LONG_LIMIT   = MAX_PACKET - (ANSWER_LEN + 1);

    localparam logic [POS_W-1:0]  POS_FLAGS_HI = POS_W'(2);
    localparam logic [POS_W-1:0]  POS_FLAGS_LO = POS_W'(3);
    localparam logic [POS_W-1:0]  POS_ANCOUNT  = POS_W'(7);
    localparam logic [POS_W-1:0]  POS_HDR_END  = POS_W'(HEADER_LAST);
    localparam logic [POS_W-1:0]  POS_MAX      = POS_W'(MAX_PACKET);
    localparam logic [POS_W-1:0]  POS_LONG     = POS_W'(LONG_LIMIT);
    localparam logic [TAIL_W-1:0] TAIL_DONE    = TAIL_W'(TAIL_LEN);

    localparam logic [7:0]  FLAG_SET_MASK = 8'h80;
    localparam logic [7:0]  ANCOUNT_ONE   = 8'h01;
    localparam logic [31:0] ANSWER_IP_RST = 32'hC0A8_0401;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_NAME   = 4'b0010,
        PH_TAIL   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_DROP   = 2'd1,
        KIND_ANSWER = 2'd2
    } kind_t;

    // What one accepted query byte asks the output side to send.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        kind_t      kind;
    } desc_t;

    // Fixed A record: pointer to the question name, type A, class IN, TTL 60, length 4, address.
    function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                               input logic [31:0] ip);
        logic [7:0] b;
        begin
            case (idx)
                4'd0:    b = 8'hC0;
                4'd1:    b = 8'h0C;
                4'd3:    b = 8'h01;
                4'd5:    b = 8'h01;
                4'd9:    b = 8'h3C;
                4'd11:   b = 8'h04;
                4'd12:   b = ip[31:24];
                4'd13:   b = ip[23:16];
                4'd14:   b = ip[15:8];
                4'd15:   b = ip[7:0];
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

@@ rtl/dqfa_ifs.sv @@
// Stream and configuration channel interfaces of the DNS fixed-answer responder.
interface dqfa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dqfa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       dropped;
    modport source (output valid, output out_byte, output out_last, output dropped, input ready);
    modport sink   (input valid, input out_byte, input out_last, input dropped, output ready);
endinterface

interface dqfa_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] answer_ip;
    modport source (output valid, output answer_ip, input ready);
    modport sink   (input valid, input answer_ip, output ready);
endinterface

@@ rtl/dns_query_to_fixed_answer_unit.sv @@
// Top level of the DNS query to fixed answer responder.
// Takes a DNS query one byte per beat on in_ch and streams the reply on out_ch. The 12
// header bytes pass with QR and RA set and ANCOUNT[7:0] set to 1; the question name and its
// four type/class bytes pass unchanged; later query bytes are dropped. On the query's final
// beat a 16-byte A record carrying the configured address follows, its last beat flagged.
// Queries shorter than a full question, or whose answer would pass 512 bytes, end with a
// single beat of byte 0 with out_last and dropped set: discard the whole reply frame.
// Rate: one input beat per cycle while the output keeps up. The parser decides each byte in
// the accept cycle and hands a work entry to the output sequencer, which moves one beat per
// cycle into the output register while the output keeps up; a final query byte occupies the
// sequencer for its own byte plus the answer record, and input is held off for that burst.
// answer_ip is written through cfg; write it only while the block is idle. No clearing pass.
module dns_query_to_fixed_answer_unit (
    input  logic       clk,
    input  logic       rst_n,
    dqfa_in_if.sink    in_ch,
    dqfa_out_if.source out_ch,
    dqfa_cfg_if.sink   cfg
);
    import dqfa_pkg::*;

    logic        cfg_write;
    logic [31:0] ip_reg;
    logic        can_take;
    logic        accept;
    logic        produce;
    desc_t       desc;

    // Configuration: always ready, one register.
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg <= ANSWER_IP_RST;
        end
        else if (cfg_write)
        begin
            ip_reg <= cfg.answer_ip;
        end
    end

    // Accept a query beat whenever the sequencer can take its work this cycle.
    assign in_ch.ready = can_take;
    assign accept      = in_ch.valid && can_take;

    dqfa_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (in_ch.data_byte),
        .last_byte (in_ch.last_byte),
        .produce   (produce),
        .desc      (desc)
    );

    dqfa_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (produce),
        .desc_in   (desc),
        .answer_ip (ip_reg),
        .can_take  (can_take),
        .out_ch    (out_ch)
    );

endmodule

@@ rtl/dqfa_parser.sv @@
// Query parser: tracks header, name and type/class bytes and decides what each byte sends.
module dqfa_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output logic            produce,
    output dqfa_pkg::desc_t desc
);
    import dqfa_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    phase_t            phase_reg, phase_next;
    logic [TAIL_W-1:0] tail_reg, tail_next;
    logic              long_reg, long_next;
    logic              emit;
    logic [7:0]        ob;

    always_comb
    begin
        phase_next = phase_reg;
        tail_next  = tail_reg;
        long_next  = long_reg;
        emit       = 1'b0;
        ob         = data_byte;
        unique case (phase_reg)
            PH_HEADER:
            begin
                emit = 1'b1;
                if (pos_reg == POS_FLAGS_HI || pos_reg == POS_FLAGS_LO)
                begin
                    ob = data_byte | FLAG_SET_MASK;
                end
                else if (pos_reg == POS_ANCOUNT)
                begin
                    ob = ANCOUNT_ONE;
                end
                if (pos_reg >= POS_HDR_END)
                begin
                    phase_next = PH_NAME;
                end
            end
            PH_NAME:
            begin
                long_next = long_reg | (pos_reg > POS_LONG);
                emit      = !long_next;
                if (data_byte == 8'h00)
                begin
                    phase_next = PH_TAIL;
                    tail_next  = '0;
                end
            end
            PH_TAIL:
            begin
                long_next = long_reg | (pos_reg > POS_LONG);
                emit      = !long_next;
                tail_next = tail_reg + TAIL_W'(1);
                if (tail_next >= TAIL_DONE)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                emit = 1'b0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        pos_next = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;

        desc.data = ob;
        if (!last_byte)
        begin
            desc.has_byte = emit;
            desc.kind     = KIND_NONE;
        end
        else if (phase_next != PH_DONE || long_next)
        begin
            desc.has_byte = 1'b0;
            desc.kind     = KIND_DROP;
        end
        else
        begin
            desc.has_byte = emit;
            desc.kind     = KIND_ANSWER;
        end
        produce = accept && (desc.has_byte || desc.kind != KIND_NONE);

        // Return to the start of a packet after every final byte.
        if (last_byte)
        begin
            pos_next   = '0;
            phase_next = PH_HEADER;
            tail_next  = '0;
            long_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_HEADER;
            tail_reg  <= '0;
            long_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            tail_reg  <= tail_next;
            long_reg  <= long_next;
        end
    end

endmodule

@@ rtl/dqfa_serializer.sv @@
// Output sequencer: holds one byte's work and streams its beats into the output register.
module dqfa_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  dqfa_pkg::desc_t desc_in,
    input  logic [31:0]     answer_ip,
    output logic            can_take,
    dqfa_out_if.source      out_ch
);
    import dqfa_pkg::*;

    logic                 desc_valid_reg;
    desc_t                desc_reg;
    logic                 byte_pend_reg;
    logic [ANS_IDX_W-1:0] idx_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;
    logic                 dropped_reg;
    logic [7:0]           beat_byte;
    logic                 beat_last;
    logic                 beat_drop;
    logic                 advance;

    always_comb
    begin
        beat_byte = desc_reg.data;
        beat_last = 1'b0;
        beat_drop = 1'b0;
        if (!byte_pend_reg)
        begin
            unique case (desc_reg.kind)
                KIND_DROP:
                begin
                    beat_byte = 8'h00;
                    beat_last = 1'b1;
                    beat_drop = 1'b1;
                end
                KIND_ANSWER:
                begin
                    beat_byte = answer_byte(idx_reg, answer_ip);
                    beat_last = (idx_reg == ANS_IDX_W'(ANSWER_LEN - 1));
                end
                default:
                begin
                    beat_last = 1'b1;
                end
            endcase
        end
        else
        begin
            beat_last = (desc_reg.kind == KIND_NONE);
        end
    end

    assign advance  = desc_valid_reg && (!out_valid_reg || out_ch.ready);
    assign can_take = !desc_valid_reg || (advance && beat_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            byte_pend_reg  <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                desc_valid_reg <= 1'b1;
                byte_pend_reg  <= desc_in.has_byte;
                idx_reg        <= '0;
            end
            else if (advance)
            begin
                if (beat_last)
                begin
                    desc_valid_reg <= 1'b0;
                end
                else if (byte_pend_reg)
                begin
                    byte_pend_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + ANS_IDX_W'(1);
                end
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= desc_in;
        end
        if (advance)
        begin
            out_byte_reg <= beat_byte;
            out_last_reg <= beat_last && (desc_reg.kind != KIND_NONE);
            dropped_reg  <= beat_drop;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.out_last = out_last_reg;
    assign out_ch.dropped  = dropped_reg;

endmodule

@@ rtl/dqfa_checker.sv @@
// Port-level checker for the DNS fixed-answer responder, bound to the top level.
module dqfa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last,
    input logic       dropped
);

    // A drop flag only ever rides on the final beat of a reply.
    a_drop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> out_last)
        else $error("dropped set on a non-final beat");

    // A drop beat carries a zero byte.
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> out_byte == 8'h00)
        else $error("drop beat carries a nonzero byte");

    // A stalled beat holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(out_last) && $stable(dropped))
        else $error("stalled output beat changed");

    // Nothing comes out in the first cycle after reset.
    a_quiet_after_reset: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind dns_query_to_fixed_answer_unit dqfa_checker u_dqfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last),
    .dropped   (out_ch.dropped)
);
